// ===== rtl/rgb_led_pwm_mixer_defines.svh =====
// ============================================================================
// RGB LED PWM mixer assertion macros
// Shared property wrappers for the concurrent checks of the mixer.
// ============================================================================
`ifndef RGB_LED_PWM_MIXER_DEFINES_SVH
`define RGB_LED_PWM_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLPM_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rlpm_pkg.sv =====
// ============================================================================
// RGB LED PWM mixer package
// Types, key codes, preset tables and fade script lookup shared by the mixer.
// ============================================================================
`default_nettype none

package rlpm_pkg;

    localparam int LVL_W          = 4;
    localparam int KEY_W          = 5;
    localparam int STEP_W         = 16;
    localparam int IDX_W          = 6;
    localparam int PWM_STEPS_DEF  = 10;

    localparam logic [LVL_W-1:0]  LEVEL_MAX        = 4'd10;
    localparam logic [LVL_W-1:0]  LEVEL_RESET      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TICKS_RESET = 16'd1340;

    localparam logic [LVL_W-1:0]  LVL_INC = 4'h1;
    localparam logic [LVL_W-1:0]  LVL_DEC = 4'hF;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_STEP_LO   = 5'd1;
    localparam logic [KEY_W-1:0] KEY_STEP_HI   = 5'd3;
    localparam logic [KEY_W-1:0] KEY_PRESET_LO = 5'd4;
    localparam logic [KEY_W-1:0] KEY_PRESET_HI = 5'd11;
    localparam logic [KEY_W-1:0] KEY_RAISE     = 5'd12;
    localparam logic [KEY_W-1:0] KEY_FADE_LO   = 5'd13;
    localparam logic [KEY_W-1:0] KEY_FADE_HI   = 5'd15;
    localparam logic [KEY_W-1:0] KEY_LOWER     = 5'd16;
    localparam logic [KEY_W-1:0] KEY_FADE_BASE = 5'd12;

    typedef enum logic [1:0] {
        FADE_NONE,
        FADE_ONE,
        FADE_TWO,
        FADE_THREE
    } t_fade;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STEP,
        ACT_PRESET,
        ACT_RAISE,
        ACT_FADE,
        ACT_LOWER
    } t_key_act;

    // Element 0 is red, 1 is green, 2 is blue.
    typedef logic [0:2][LVL_W-1:0] t_levels;
    typedef logic [0:2]            t_pins;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic             red_pin;
        logic             green_pin;
        logic             blue_pin;
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
        logic             fade_busy;
    } t_out_item;

    localparam t_levels PRESET_TAB [0:7] = '{
        '{4'd5,  4'd5,  4'd5},
        '{4'd2,  4'd2,  4'd8},
        '{4'd2,  4'd2,  4'd10},
        '{4'd1,  4'd8,  4'd10},
        '{4'd10, 4'd10, 4'd10},
        '{4'd4,  4'd8,  4'd7},
        '{4'd2,  4'd8,  4'd2},
        '{4'd5,  4'd10, 4'd8}
    };

    localparam t_levels FADE_START_TAB [0:2] = '{
        '{4'd10, 4'd10, 4'd1},
        '{4'd10, 4'd5,  4'd10},
        '{4'd2,  4'd2,  4'd10}
    };

    // Number of level changes in each fade script.
    function automatic logic [IDX_W-1:0] fade_len(input t_fade prog);
        logic [IDX_W-1:0] len;
        begin
            case (prog)
                FADE_ONE:   len = 6'd45;
                FADE_TWO:   len = 6'd35;
                FADE_THREE: len = 6'd38;
                default:    len = '0;
            endcase
            return len;
        end
    endfunction

    // Per-channel addend (modulo 16) for step idx of a fade script.
    function automatic t_levels fade_delta(input t_fade prog, input logic [IDX_W-1:0] idx);
        t_levels d;
        begin
            d = '0;
            case (prog)
                FADE_ONE: begin
                    if (idx < 6'd10)      d[0] = LVL_DEC;
                    else if (idx < 6'd20) d[0] = LVL_INC;
                    else if (idx < 6'd30) d[1] = LVL_DEC;
                    else if (idx < 6'd40) d[1] = LVL_INC;
                    else begin
                        d[1] = LVL_DEC;
                        d[2] = LVL_INC;
                    end
                end
                FADE_TWO: begin
                    if (idx < 6'd5)       d[1] = LVL_INC;
                    else if (idx < 6'd15) d[2] = LVL_DEC;
                    else if (idx < 6'd25) d[2] = LVL_INC;
                    else                  d[0] = LVL_DEC;
                end
                FADE_THREE: begin
                    if (idx < 6'd8)       d[1] = LVL_INC;
                    else if (idx < 6'd18) d[2] = LVL_DEC;
                    else if (idx < 6'd28) d[2] = LVL_INC;
                    else                  d[1] = LVL_DEC;
                end
                default: d = '0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rlpm_in_stage.sv =====
// ============================================================================
// RGB LED PWM mixer input stage
// Registers one incoming item and holds it until the core takes it.
// ============================================================================
`default_nettype none

module rlpm_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rlpm_pkg::t_in_item i_item,
    output logic               o_valid,
    output rlpm_pkg::t_in_item o_item,
    input  logic               i_take
);
    import rlpm_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The register is free when empty or when its item leaves this cycle.
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/rlpm_core.sv =====
// ============================================================================
// RGB LED PWM mixer core
// Level, phase and fade state with the result register.
// ============================================================================
`default_nettype none
`include "rgb_led_pwm_mixer_defines.svh"

module rlpm_core #(
    parameter int PWM_STEPS = rlpm_pkg::PWM_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  rlpm_pkg::t_in_item         i_in_item,
    output logic                       o_take,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rlpm_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_wr,
    input  logic [rlpm_pkg::STEP_W-1:0] i_cfg_data
);
    import rlpm_pkg::*;

    localparam int PH_W  = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
    localparam int CMP_W = (PH_W > LVL_W) ? PH_W : LVL_W;
    localparam logic [PH_W:0] PH_LIMIT = (PH_W + 1)'(PWM_STEPS);

    logic [STEP_W-1:0] r_step_ticks;
    logic [PH_W-1:0]   r_phase,  n_phase;
    t_levels           r_levels, n_levels;
    t_pins             r_pins,   n_pins;
    t_fade             r_prog,   n_prog;
    logic [IDX_W-1:0]  r_idx,    n_idx;
    logic [STEP_W-1:0] r_cnt,    n_cnt;
    logic              r_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              fire;
    logic              advance;
    t_key_act          key_act;
    logic [KEY_W-1:0]  key;
    logic [1:0]        step_ch;
    t_levels           fade_act;
    logic [STEP_W-1:0] cnt_inc;
    logic [PH_W:0]     ph_inc;

    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = i_in_valid && advance;
    assign o_take  = fire;

    // Key decode.
    always_comb begin
        key     = i_in_item.key_code;
        step_ch = 2'(key - KEY_STEP_LO);
        if (key >= KEY_STEP_LO && key <= KEY_STEP_HI) begin
            key_act = ACT_STEP;
        end else if (key >= KEY_PRESET_LO && key <= KEY_PRESET_HI) begin
            key_act = ACT_PRESET;
        end else if (key == KEY_RAISE) begin
            key_act = ACT_RAISE;
        end else if (key >= KEY_FADE_LO && key <= KEY_FADE_HI) begin
            key_act = ACT_FADE;
        end else if (key == KEY_LOWER) begin
            key_act = ACT_LOWER;
        end else begin
            key_act = ACT_NONE;
        end
    end

    // Next state for the item in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_levels = r_levels;
        n_pins   = r_pins;
        n_prog   = r_prog;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        fade_act = fade_delta(r_prog, r_idx);
        cnt_inc  = r_cnt + 1'b1;
        ph_inc   = {1'b0, r_phase} + 1'b1;

        if (i_in_item.cmd == CMD_TICK) begin
            // Fade timing first, then the phase and the pin compare.
            if (r_prog != FADE_NONE) begin
                if (cnt_inc >= r_step_ticks) begin
                    n_cnt = '0;
                    if (r_idx < fade_len(r_prog)) begin
                        for (int c = 0; c < 3; c++) begin
                            n_levels[c] = r_levels[c] + fade_act[c];
                        end
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_prog = FADE_NONE;
                        n_idx  = '0;
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            n_phase = (ph_inc >= PH_LIMIT) ? '0 : ph_inc[PH_W-1:0];
            for (int c = 0; c < 3; c++) begin
                n_pins[c] = CMP_W'(n_phase) < CMP_W'(n_levels[c]);
            end
        end else if (r_prog == FADE_NONE) begin
            case (key_act)
                ACT_STEP: begin
                    for (int c = 0; c < 3; c++) begin
                        if (2'(c) == step_ch) begin
                            n_levels[c] = (r_levels[c] == LEVEL_MAX) ? '0
                                                                      : r_levels[c] + 1'b1;
                        end
                    end
                end
                ACT_PRESET: begin
                    n_levels = PRESET_TAB[3'(key - KEY_PRESET_LO)];
                end
                ACT_RAISE: begin
                    if (r_levels[0] != LEVEL_MAX && r_levels[1] != LEVEL_MAX &&
                        r_levels[2] != LEVEL_MAX) begin
                        for (int c = 0; c < 3; c++) begin
                            n_levels[c] = r_levels[c] + 1'b1;
                        end
                    end
                end
                ACT_FADE: begin
                    n_levels = FADE_START_TAB[2'(key - KEY_FADE_LO)];
                    n_prog   = t_fade'(2'(key - KEY_FADE_BASE));
                    n_idx    = '0;
                    n_cnt    = '0;
                end
                ACT_LOWER: begin
                    if (r_levels[0] != '0 && r_levels[1] != '0 && r_levels[2] != '0) begin
                        for (int c = 0; c < 3; c++) begin
                            n_levels[c] = r_levels[c] - 1'b1;
                        end
                    end
                end
                default: begin
                    n_levels = r_levels;
                end
            endcase
        end

        n_out_item.red_pin     = n_pins[0];
        n_out_item.green_pin   = n_pins[1];
        n_out_item.blue_pin    = n_pins[2];
        n_out_item.red_level   = n_levels[0];
        n_out_item.green_level = n_levels[1];
        n_out_item.blue_level  = n_levels[2];
        n_out_item.fade_busy   = (n_prog != FADE_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks <= STEP_TICKS_RESET;
        end else if (i_cfg_wr) begin
            r_step_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_levels <= {3{LEVEL_RESET}};
            r_pins   <= '1;
            r_prog   <= FADE_NONE;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_levels <= n_levels;
            r_pins   <= n_pins;
            r_prog   <= n_prog;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `RLPM_ASSERT(a_level_range, i_clk, i_rst_n, 1'b1, (r_levels[0] <= LEVEL_MAX) && (r_levels[1] <= LEVEL_MAX) && (r_levels[2] <= LEVEL_MAX), "channel level left the 0 to 10 range")
    `RLPM_ASSERT(a_idle_clear, i_clk, i_rst_n, r_prog == FADE_NONE, (r_idx == '0) && (r_cnt == '0), "fade counters not cleared while no fade runs")
    `RLPM_ASSERT(a_idx_bound, i_clk, i_rst_n, r_prog != FADE_NONE, r_idx <= fade_len(r_prog), "fade step index ran past its script")
    `RLPM_ASSERT_NEXT(a_key_keeps_phase, i_clk, i_rst_n, fire && (i_in_item.cmd == CMD_KEY), (r_phase == $past(r_phase)) && (r_pins == $past(r_pins)), "key event moved the PWM phase or pins")

endmodule

`default_nettype wire

// ===== rtl/rgb_led_pwm_mixer.sv =====
// ============================================================================
// RGB LED PWM mixer
// Three-channel active-low PWM mixer driven by tick and key events.
// ============================================================================
//
//  Channel   Direction  Signals                          Transfer when
//  -------   ---------  -------------------------------  -------------------------
//  in        sink       i_in_valid, o_in_stall, i_in_item   valid high, stall low
//  out       source     o_out_valid, i_out_stall, o_out_item valid high, stall low
//  cfg       sink       i_cfg_valid, o_cfg_ready, i_cfg_data valid and ready high
//
//  Every input transfer produces exactly one output transfer: the item waits
//  in the input register, then the core updates the state and loads the
//  result register.
//  The core accepts one item per cycle while the output does not stall; its
//  state update is a single pass of compares, small adds and table lookups.
//  Reset is synchronous and active low; it restores all levels to nine, the
//  pins to off, the phase and fade state to zero and step_ticks to 1340.
//  A stall on the output holds the result register, which in turn holds the
//  input register and raises o_in_stall once that register is also full.
//
`default_nettype none

module rgb_led_pwm_mixer #(
    parameter int PWM_STEPS = rlpm_pkg::PWM_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Event input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rlpm_pkg::t_in_item          i_in_item,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rlpm_pkg::t_out_item         o_out_item,
    // Configuration write channel for step_ticks.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rlpm_pkg::STEP_W-1:0] i_cfg_data
);
    import rlpm_pkg::*;

    logic     stg_valid;
    t_in_item stg_item;
    logic     core_take;
    logic     cfg_wr;

    // The step_ticks register can take a write in any cycle; the user must issue
    // writes only while the block is idle; the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Input register: decouples the upstream stall from the result register.
    rlpm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (stg_valid),
        .o_item  (stg_item),
        .i_take  (core_take)
    );

    // Core: tick handling (fade step, phase, pin compare) and key handling,
    // followed by the result register.
    rlpm_core #(
        .PWM_STEPS (PWM_STEPS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (stg_valid),
        .i_in_item   (stg_item),
        .o_take      (core_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ============================================================================
// RGB LED PWM mixer testbench
// Drives tick and key transfers into the mixer under random idling and one long
// output hold-off, predicts every result with an independent model of levels,
// pins and fade scripts, and compares each result field by field.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    import rlpm_pkg::*;

    localparam int          PWM_PERIOD   = 10;
    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE       = 8;
    localparam int          PHASE_ITEMS  = 175;
    localparam int          NUM_PHASES   = 8;
    localparam logic [3:0]  LEVEL_TOP    = 4'd10;
    localparam logic [3:0]  LEVEL_START  = 4'd9;
    localparam logic [15:0] STEP_RESET   = 16'd1340;

    // Step interval for each random phase. The list holds both extremes of
    // the register, zero (which acts as one) and a few small values, so that
    // fades run to completion often enough to be exercised end to end.
    localparam logic [15:0] PHASE_STEPS [0:NUM_PHASES-1] = '{
        16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd3, 16'd1, 16'd5, 16'd2
    };

    // Opening sequence, packed as {cmd, key_code}. It walks the unknown
    // codes, the channel step keys up to the wrap from ten to zero, the
    // blocked raise and lower, every preset, an allowed lower, and a fade
    // start followed by keys that must be ignored.
    localparam int OPEN_LEN = 26;
    localparam logic [5:0] OPENING [0:OPEN_LEN-1] = '{
        {CMD_TICK, 5'd0},      {CMD_TICK, 5'd31},
        {CMD_KEY, 5'd0},       {CMD_KEY, 5'd17},      {CMD_KEY, 5'd31},
        {CMD_KEY, KEY_STEP_LO}, {CMD_KEY, 5'd2},      {CMD_KEY, KEY_STEP_HI},
        {CMD_KEY, KEY_STEP_LO},
        {CMD_KEY, KEY_RAISE},  {CMD_KEY, KEY_LOWER},
        {CMD_KEY, KEY_PRESET_LO}, {CMD_KEY, 5'd5},    {CMD_KEY, 5'd6},
        {CMD_KEY, 5'd7},       {CMD_KEY, 5'd9},       {CMD_KEY, 5'd10},
        {CMD_KEY, KEY_PRESET_HI}, {CMD_KEY, 5'd8},
        {CMD_KEY, KEY_RAISE},  {CMD_KEY, KEY_LOWER},
        {CMD_TICK, 5'd21},
        {CMD_KEY, KEY_FADE_LO}, {CMD_KEY, 5'd2},      {CMD_TICK, 5'd10},
        {CMD_KEY, 5'd14}
    };

    // ------------------------------------------------------------------------
    // Scoreboard: an independent model of the mixer plus the queue of results
    // it expects. note_event advances the model for one accepted input
    // transfer; check_result compares one accepted output transfer.
    // ------------------------------------------------------------------------
    class led_mix_board;
        logic [15:0] step_ticks;
        logic [3:0]  pwm_phase;
        logic [3:0]  level [3];
        logic        pin [3];
        t_fade       fade;
        logic [5:0]  fade_idx;
        logic [15:0] fade_count;
        int          seg_len [3][5];
        int          seg_d [3][5][3];
        logic [3:0]  preset_lv [8][3];
        logic [3:0]  fade_lv [3][3];
        t_out_item   expected_outs [$];
        int          mismatches;

        function new();
            step_ticks = STEP_RESET;
            pwm_phase  = '0;
            foreach (level[c]) begin
                level[c] = LEVEL_START;
                pin[c]   = 1'b1;
            end
            fade       = FADE_NONE;
            fade_idx   = '0;
            fade_count = '0;
            mismatches = 0;
            seg_len = '{'{10, 10, 10, 10, 5}, '{5, 10, 10, 10, 0}, '{8, 10, 10, 10, 0}};
            seg_d = '{
                '{'{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 1, 0}, '{0, -1, 1}},
                '{'{0, 1, 0}, '{0, 0, -1}, '{0, 0, 1}, '{-1, 0, 0}, '{0, 0, 0}},
                '{'{0, 1, 0}, '{0, 0, -1}, '{0, 0, 1}, '{0, -1, 0}, '{0, 0, 0}}
            };
            preset_lv = '{
                '{4'd5, 4'd5, 4'd5},   '{4'd2, 4'd2, 4'd8},
                '{4'd2, 4'd2, 4'd10},  '{4'd1, 4'd8, 4'd10},
                '{4'd10, 4'd10, 4'd10}, '{4'd4, 4'd8, 4'd7},
                '{4'd2, 4'd8, 4'd2},   '{4'd5, 4'd10, 4'd8}
            };
            fade_lv = '{'{4'd10, 4'd10, 4'd1}, '{4'd10, 4'd5, 4'd10}, '{4'd2, 4'd2, 4'd10}};
        endfunction

        function void set_step(logic [15:0] v);
            step_ticks = v;
        endfunction

        function int pending();
            return expected_outs.size();
        endfunction

        function int script_len(int p);
            int n;
            n = 0;
            for (int s = 0; s < 5; s++) n += seg_len[p][s];
            return n;
        endfunction

        // Applies step idx of script p; the segment is found by counting down.
        function void fade_step(int p, int idx);
            int rest;
            rest = idx;
            for (int s = 0; s < 5; s++) begin
                if (rest < seg_len[p][s]) begin
                    for (int c = 0; c < 3; c++)
                        level[c] = 4'(int'(level[c]) + seg_d[p][s][c]);
                    return;
                end
                rest -= seg_len[p][s];
            end
        endfunction

        // The fade counter and step come first, then the phase and the pins.
        function void do_tick();
            int prog;
            if (fade != FADE_NONE) begin
                prog = int'(fade) - 1;
                fade_count = fade_count + 16'd1;
                if (fade_count >= step_ticks) begin
                    fade_count = '0;
                    if (fade_idx < script_len(prog)) begin
                        fade_step(prog, fade_idx);
                        fade_idx = fade_idx + 6'd1;
                    end else begin
                        fade     = FADE_NONE;
                        fade_idx = '0;
                    end
                end
            end
            pwm_phase = pwm_phase + 4'd1;
            if (pwm_phase >= PWM_PERIOD) pwm_phase = '0;
            for (int c = 0; c < 3; c++) pin[c] = (pwm_phase < level[c]);
        endfunction

        function void do_key(logic [KEY_W-1:0] k);
            int  c;
            bit  any_top;
            bit  any_zero;
            if (fade != FADE_NONE) return;
            any_top  = (level[0] == LEVEL_TOP) || (level[1] == LEVEL_TOP) ||
                       (level[2] == LEVEL_TOP);
            any_zero = (level[0] == 4'd0) || (level[1] == 4'd0) || (level[2] == 4'd0);
            if (k >= KEY_STEP_LO && k <= KEY_STEP_HI) begin
                c = int'(k - KEY_STEP_LO);
                level[c] = (level[c] == LEVEL_TOP) ? 4'd0 : level[c] + 4'd1;
            end else if (k >= KEY_PRESET_LO && k <= KEY_PRESET_HI) begin
                for (c = 0; c < 3; c++) level[c] = preset_lv[int'(k - KEY_PRESET_LO)][c];
            end else if (k == KEY_RAISE) begin
                if (!any_top)
                    for (c = 0; c < 3; c++) level[c] = level[c] + 4'd1;
            end else if (k >= KEY_FADE_LO && k <= KEY_FADE_HI) begin
                for (c = 0; c < 3; c++) level[c] = fade_lv[int'(k - KEY_FADE_LO)][c];
                fade       = t_fade'(2'(k - KEY_FADE_BASE));
                fade_idx   = '0;
                fade_count = '0;
            end else if (k == KEY_LOWER) begin
                if (!any_zero)
                    for (c = 0; c < 3; c++) level[c] = level[c] - 4'd1;
            end
        endfunction

        function void note_event(t_in_item it);
            t_out_item e;
            if (it.cmd == CMD_TICK) do_tick();
            else do_key(it.key_code);
            e.red_pin     = pin[0];
            e.green_pin   = pin[1];
            e.blue_pin    = pin[2];
            e.red_level   = level[0];
            e.green_level = level[1];
            e.blue_level  = level[2];
            e.fade_busy   = (fade != FADE_NONE);
            expected_outs.push_back(e);
        endfunction

        function void compare_field(string name, int e, int a);
            if (e != a) begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_outs.size() == 0) begin
                $error("result transfer arrived with nothing expected");
                mismatches++;
                return;
            end
            e = expected_outs.pop_front();
            compare_field("red_pin", e.red_pin, got.red_pin);
            compare_field("green_pin", e.green_pin, got.green_pin);
            compare_field("blue_pin", e.blue_pin, got.blue_pin);
            compare_field("red_level", e.red_level, got.red_level);
            compare_field("green_level", e.green_level, got.green_level);
            compare_field("blue_level", e.blue_level, got.blue_level);
            compare_field("fade_busy", e.fade_busy, got.fade_busy);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every block input starts at a known value; reset starts low.
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        o_cfg_ready;

    led_mix_board board;
    bit           no_idle  = 1'b0;  // When set, neither side inserts idle cycles.
    bit           hold_req = 1'b0;  // Asks the result side for one long hold-off.
    int           cycle_count = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    rgb_led_pwm_mixer #(
        .PWM_STEPS(PWM_PERIOD)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Input side. All drives happen with nonblocking assignments right after a
    // rising edge, and all samples read the values from before that edge, so
    // the outcome does not depend on the order of processes in a time step.
    // ------------------------------------------------------------------------

    // Offers one event after a random idle gap and holds it until the block
    // takes the transfer. When the gap is zero, valid simply stays high, so
    // it is never lowered and raised again within one time step.
    task automatic send_event(input logic cmd, input logic [KEY_W-1:0] key);
        int       gap;
        t_in_item it;
        gap         = no_idle ? 0 : $urandom_range(0, 3);
        it.cmd      = cmd;
        it.key_code = key;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_event(it);
    endtask

    // Waits until every expected result has been taken. Each event yields
    // exactly one result, so the block is idle once the queue is empty.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Writes the step interval through the configuration channel.
    task automatic write_step(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_step(v);
    endtask

    // ------------------------------------------------------------------------
    // Result side. For each result it may first raise stall, unless no_idle
    // is set, then keeps stall low until a transfer happens. Once per run it
    // holds stall high for a long stretch, counted here, so that the block
    // backs up and stalls its input while the sender keeps offering events.
    // ------------------------------------------------------------------------
    initial begin : result_side
        int wait_cycles;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
                if (wait_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Every accepted result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the opening sequence at the reset step interval,
    // then random phases, each under a new step interval written while idle.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int              r;
        int              u;
        logic [KEY_W-1:0] key;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The opening runs at the reset interval, so its fade start stays
        // busy and carries over into the first random phase.
        for (int i = 0; i < OPEN_LEN; i++) send_event(OPENING[i][5], OPENING[i][4:0]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_step(PHASE_STEPS[p]);
            no_idle  = (p == 5);
            hold_req = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (board.fade != FADE_NONE) begin
                    // While a fade runs, mostly ticks; the odd key must be ignored.
                    if ($urandom_range(0, 99) < 85)
                        send_event(CMD_TICK, 5'($urandom_range(0, 31)));
                    else
                        send_event(CMD_KEY, 5'($urandom_range(0, 31)));
                end else if ($urandom_range(0, 99) < 45) begin
                    send_event(CMD_TICK, 5'($urandom_range(0, 31)));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        key = 5'($urandom_range(KEY_FADE_LO, KEY_FADE_HI));
                    end else if (r < 14) begin
                        // Unknown codes: zero or anything above the lower key.
                        u   = $urandom_range(0, 15);
                        key = (u == 0) ? 5'd0 : 5'(16 + u);
                    end else begin
                        u   = $urandom_range(1, 13);
                        key = (u == 13) ? KEY_LOWER : 5'(u);
                    end
                    send_event(CMD_KEY, key);
                end
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rlpm_pkg.sv
rtl/rlpm_in_stage.sv
rtl/rlpm_core.sv
rtl/rgb_led_pwm_mixer.sv
tb/testbench.sv
